// File: src/rational_accumulator_alu_top_defines.svh
// assertion macros for the rational accumulator alu
`ifndef RATIONAL_ACCUMULATOR_ALU_TOP_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_ALU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RA_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RA_ASSERT_RESET(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RA_ASSERT_IMPL(label, clk, rst_n, prop)
`define RA_ASSERT_RESET(label, clk, prop)
`endif
`endif

// File: src/ra_pkg.sv
package ra_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int WIDE_W = 2 * VALUE_WIDTH;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_DIV   = 3'd4,
    CMD_MULNU = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // one multiplier step request and its reply
  typedef struct packed {
    logic start;
    logic [VALUE_WIDTH-1:0] a;
    logic [VALUE_WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [WIDE_W-1:0] p;
  } mul_rsp_t;
endpackage

// File: src/ra_if.sv
interface ra_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic signed [ra_pkg::VALUE_WIDTH-1:0] operand_num;
  logic signed [ra_pkg::VALUE_WIDTH-1:0] operand_denom;
  modport source (output valid, output cmd, output operand_num, output operand_denom,
                  input ready);
  modport sink (input valid, input cmd, input operand_num, input operand_denom,
                output ready);
endinterface

interface ra_out_if;
  logic        valid;
  logic        ready;
  logic signed [ra_pkg::VALUE_WIDTH-1:0] result_num;
  logic [ra_pkg::VALUE_WIDTH-2:0] result_denom;
  logic [1:0]  status;
  modport source (output valid, output result_num, output result_denom, output status,
                  input ready);
  modport sink (input valid, input result_num, input result_denom, input status,
                output ready);
endinterface

// File: src/ra_mul.sv
// unsigned 32x32 multiplier, shift-add over one bit per cycle
module ra_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  ra_pkg::mul_req_t  req,
  output ra_pkg::mul_rsp_t  rsp
);
  localparam int W = ra_pkg::VALUE_WIDTH;
  logic [W-1:0]   mcand_r;
  logic [W-1:0]   mplier_r;
  logic [2*W-1:0] acc_r;
  logic [$clog2(W+1)-1:0] cnt_r;
  logic busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r   <= 1'b1;
        mcand_r  <= req.a;
        mplier_r <= req.b;
        acc_r    <= '0;
        cnt_r    <= '0;
      end else if (busy_r) begin
        if (mplier_r[0])
          acc_r <= acc_r + ({{W{1'b0}}, mcand_r} << cnt_r);
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == W[$clog2(W+1)-1:0] - 1'b1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.p    = acc_r;
endmodule

// File: src/rational_accumulator_alu_top.sv
// channel   | dir | payload
// in_*      | in  | cmd, operand_num, operand_denom
// out_*     | out | result_num, result_denom, status
// one transaction is handled at a time; in_ready is high only in idle
// a finished result waits in the output register, the next one is held until it is taken
// products come from a bit-serial multiplier: two per mul/div, three for add/sub, none for load
// gcd and the two exact divisions run one quotient bit per cycle on a 64-bit restoring
// divider, one full division for each euclid step
// rst_n is synchronous, active low, and sets the accumulator to 0/1
`include "rational_accumulator_alu_top_defines.svh"
module rational_accumulator_alu_top (
  input logic clk,
  input logic rst_n,
  ra_in_if.sink    in_ch,
  ra_out_if.source out_ch
);
  localparam int W  = ra_pkg::VALUE_WIDTH;
  localparam int WW = ra_pkg::WIDE_W;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_M4, S_M4W,
    S_SUM, S_GCD, S_DIV, S_DIVN, S_DIVD, S_FIT, S_OUT
  } state_t;

  // what the divider result is used for
  typedef enum logic [1:0] {
    DS_GCD, DS_NUM, DS_DEN
  } dsel_t;

  state_t state_r;
  logic [2:0] cmd_r;
  logic signed [W-1:0] c_r, d_r;
  logic signed [W-1:0] acc_num_r, acc_den_r;
  logic [WW-1:0] p1_r, p2_r, p3_r;  // magnitudes of products
  logic s1_r, s2_r, s3_r;           // product signs
  logic [WW:0] n_r;                 // signed numerator (65 bits)
  logic [WW-1:0] mn_r, md_r, ga_r, gb_r, g_r;
  logic neg_r;
  // divider
  logic [WW-1:0] dq_r, drem_r, ddiv_r;
  logic [$clog2(WW+1)-1:0] dcnt_r;
  dsel_t dsel_r;
  // result being built
  logic signed [W-1:0] wnum_r;
  logic [W-2:0] wden_r;
  logic [1:0] wst_r;
  // output register
  logic signed [W-1:0] onum_r;
  logic [W-2:0] oden_r;
  logic [1:0] ost_r;
  logic ovalid_r;

  ra_pkg::mul_req_t mreq;
  ra_pkg::mul_rsp_t mrsp;
  ra_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? W'(-v) : W'(v);
  endfunction

  // pick multiplier operands per step
  always_comb begin
    mreq.start = 1'b0;
    mreq.a = '0;
    mreq.b = '0;
    case (state_r)
      S_M1: begin
        mreq.start = 1'b1;
        mreq.a = mag(acc_num_r);
        mreq.b = (cmd_r == ra_pkg::CMD_MUL || cmd_r == ra_pkg::CMD_MULNU) ? mag(c_r)
                                                                           : mag(d_r);
      end
      S_M2: begin
        mreq.start = 1'b1;
        mreq.a = mag(acc_den_r);
        mreq.b = (cmd_r == ra_pkg::CMD_DIV) ? mag(c_r) : mag(d_r);
      end
      S_M3: begin
        mreq.start = 1'b1;
        mreq.a = mag(c_r);
        mreq.b = mag(acc_den_r);
      end
      default: ;
    endcase
  end

  logic [WW:0] t1, t3, nsum;
  logic [WW:0] trial;
  always_comb begin
    t1 = s1_r ? -{1'b0, p1_r} : {1'b0, p1_r};
    t3 = s3_r ? -{1'b0, p3_r} : {1'b0, p3_r};
    nsum = (cmd_r == ra_pkg::CMD_SUB) ? t1 - t3 : t1 + t3;
    trial = {drem_r, dq_r[WW-1]} - {1'b0, ddiv_r};
  end

  localparam logic [WW-1:0] LIM = WW'(1) << (W - 1);
  logic is_add;
  assign is_add = (cmd_r == ra_pkg::CMD_ADD) || (cmd_r == ra_pkg::CMD_SUB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      acc_num_r <= '0;
      acc_den_r <= W'(1);
      ovalid_r  <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          cmd_r <= in_ch.cmd;
          c_r   <= in_ch.operand_num;
          d_r   <= in_ch.operand_denom;
          wst_r <= ra_pkg::ST_OK;
          wnum_r <= acc_num_r;
          wden_r <= acc_den_r[W-2:0];
          if (in_ch.cmd > 3'(ra_pkg::CMD_MULNU)) state_r <= S_OUT;
          else if (in_ch.operand_denom == '0 ||
                   (in_ch.cmd == 3'(ra_pkg::CMD_DIV) && in_ch.operand_num == '0)) begin
            wst_r <= ra_pkg::ST_ZERO;
            state_r <= S_OUT;
          end else if (in_ch.cmd == 3'(ra_pkg::CMD_LOAD)) begin
            n_r <= {{(WW-W+1){in_ch.operand_num[W-1]}}, in_ch.operand_num};
            md_r <= WW'(mag(in_ch.operand_denom));
            neg_r <= in_ch.operand_denom[W-1];
            state_r <= S_SUM;
          end else state_r <= S_M1;
        end
        S_M1: state_r <= S_M1W;
        S_M1W: if (mrsp.done) begin
          p1_r <= mrsp.p;
          s1_r <= acc_num_r[W-1] ^ ((cmd_r == ra_pkg::CMD_MUL || cmd_r == ra_pkg::CMD_MULNU)
                                    ? c_r[W-1] : d_r[W-1]);
          state_r <= S_M2;
        end
        S_M2: state_r <= S_M2W;
        S_M2W: if (mrsp.done) begin
          p2_r <= mrsp.p;
          s2_r <= acc_den_r[W-1] ^ ((cmd_r == ra_pkg::CMD_DIV) ? c_r[W-1] : d_r[W-1]);
          state_r <= is_add ? S_M3 : S_M4;
        end
        S_M3: state_r <= S_M3W;
        S_M3W: if (mrsp.done) begin
          p3_r <= mrsp.p;
          s3_r <= c_r[W-1] ^ acc_den_r[W-1];
          state_r <= S_M4;
        end
        S_M4: begin
          // numerator from products, denominator sign into neg
          n_r <= is_add ? nsum : (s1_r ? -{1'b0, p1_r} : {1'b0, p1_r});
          md_r <= p2_r;
          neg_r <= s2_r;
          state_r <= S_SUM;
        end
        S_M4W: state_r <= S_SUM;
        S_SUM: begin
          // fold sign: negative if numerator and denominator signs differ
          mn_r <= n_r[WW] ? WW'(-n_r) : n_r[WW-1:0];
          neg_r <= n_r[WW] ^ neg_r;
          if (n_r == '0) begin
            wnum_r <= '0;
            wden_r <= (W-1)'(1);
            if (cmd_r != ra_pkg::CMD_MULNU) begin
              acc_num_r <= '0;
              acc_den_r <= W'(1);
            end
            state_r <= S_OUT;
          end else begin
            ga_r <= n_r[WW] ? WW'(-n_r) : n_r[WW-1:0];
            gb_r <= md_r;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (gb_r == '0) begin
            g_r <= ga_r;
            ddiv_r <= ga_r;
            dq_r <= mn_r;
            drem_r <= '0;
            dcnt_r <= '0;
            dsel_r <= DS_NUM;
            state_r <= S_DIV;
          end else begin
            ddiv_r <= gb_r;
            dq_r <= ga_r;
            drem_r <= '0;
            dcnt_r <= '0;
            dsel_r <= DS_GCD;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // one restoring division bit per cycle
          if (!trial[WW]) begin
            drem_r <= trial[WW-1:0];
            dq_r <= {dq_r[WW-2:0], 1'b1};
          end else begin
            drem_r <= {drem_r[WW-2:0], dq_r[WW-1]};
            dq_r <= {dq_r[WW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == ($clog2(WW+1))'(WW - 1)) state_r <= S_DIVN;
        end
        S_DIVN: begin
          case (dsel_r)
            DS_GCD: begin
              ga_r <= gb_r;
              gb_r <= drem_r;
              state_r <= S_GCD;
            end
            DS_NUM: begin
              mn_r <= dq_r;
              ddiv_r <= g_r;
              dq_r <= md_r;
              drem_r <= '0;
              dcnt_r <= '0;
              dsel_r <= DS_DEN;
              state_r <= S_DIV;
            end
            default: begin
              md_r <= dq_r;
              state_r <= S_FIT;
            end
          endcase
        end
        S_DIVD: state_r <= S_FIT;
        S_FIT: begin
          if (md_r > LIM - 1'b1 || (neg_r ? (mn_r > LIM) : (mn_r > LIM - 1'b1))) begin
            wst_r <= ra_pkg::ST_OVF;
          end else begin
            wnum_r <= neg_r ? W'(-mn_r) : W'(mn_r);
            wden_r <= md_r[W-2:0];
            if (cmd_r != ra_pkg::CMD_MULNU) begin
              acc_num_r <= neg_r ? W'(-mn_r) : W'(mn_r);
              acc_den_r <= {1'b0, md_r[W-2:0]};
            end
          end
          state_r <= S_FIT == S_FIT ? S_OUT : S_OUT;
        end
        S_OUT: if (!ovalid_r) begin
          // hand the result to the output register once it is free
          ovalid_r <= 1'b1;
          onum_r <= wnum_r;
          oden_r <= wden_r;
          ost_r <= wst_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.result_num = onum_r;
  assign out_ch.result_denom = oden_r;
  assign out_ch.status = ost_r;

  `RA_ASSERT_IMPL(a_no_ready_busy, clk, rst_n, (state_r != S_IDLE) |-> !in_ch.ready)
  `RA_ASSERT_IMPL(a_den_pos, clk, rst_n, acc_den_r != '0 && !acc_den_r[W-1])
  `RA_ASSERT_IMPL(a_zero_den1, clk, rst_n,
    (out_ch.valid && out_ch.result_num == '0) |-> (out_ch.result_denom == (W-1)'(1)))
  `RA_ASSERT_RESET(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !ovalid_r))
endmodule
